/* sv/assert_macros.svh */
// Assertion helper macros used by triangle_face_normal
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal pipeline
// Holds widths, the Q1.14 unit constant and the normalization window.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordW = 24;
  localparam int EdgeW  = 25;
  localparam int CrossW = 51;
  localparam int MagW   = 50;
  localparam int PW     = 30;
  localparam int SW     = 62;
  localparam int LW     = 31;
  localparam int NormW  = 16;
  localparam int QW     = 15;

  localparam logic [QW-1:0] NormOne = 15'd16384;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [PW-1:0]            pmag_t;
  typedef logic [SW-1:0]            sq_t;
  typedef logic [LW-1:0]            len_t;
  typedef logic signed [NormW-1:0]  norm_t;

endpackage

/* sv/tfn_sqrt_step.sv */
// ----------------------------------------------------------------------------
// tfn_sqrt_step: one registered stage of the digit-by-digit integer sqrt
// Resolves two result bits per stage using the restoring algorithm.
// ----------------------------------------------------------------------------
module tfn_sqrt_step #(
  parameter int Stage = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [tfn_pkg::SW:0]  rem_i,
  input  logic [tfn_pkg::LW:0]  root_i,
  output logic [tfn_pkg::SW:0]  rem_o,
  output logic [tfn_pkg::LW:0]  root_o
);

  localparam int Bit0 = tfn_pkg::SW - 2 * (2 * Stage);
  localparam int Bit1 = Bit0 - 2;

  logic [tfn_pkg::SW:0] rem_a, rem_b, t0, t1;
  logic [tfn_pkg::LW:0] root_a, root_b;
  logic [tfn_pkg::SW:0] rem_nxt;
  logic [tfn_pkg::LW:0] root_nxt;

  // Two restoring iterations; root holds the result bits found so far in place,
  // so trying result bit k costs (root << (k+1)) + 4^k
  always_comb begin
    t0 = ({{(tfn_pkg::SW-tfn_pkg::LW){1'b0}}, root_i} << (Bit0 / 2 + 1))
       + ((tfn_pkg::SW+1)'(1) << Bit0);
    if (rem_i >= t0) begin
      rem_a  = rem_i - t0;
      root_a = root_i | ((tfn_pkg::LW+1)'(1) << (Bit0 / 2));
    end else begin
      rem_a  = rem_i;
      root_a = root_i;
    end
    t1 = ({{(tfn_pkg::SW-tfn_pkg::LW){1'b0}}, root_a} << (Bit1 / 2 + 1))
       + ((tfn_pkg::SW+1)'(1) << Bit1);
    if (rem_a >= t1) begin
      rem_b  = rem_a - t1;
      root_b = root_a | ((tfn_pkg::LW+1)'(1) << (Bit1 / 2));
    end else begin
      rem_b  = rem_a;
      root_b = root_a;
    end
    rem_nxt  = rem_b;
    root_nxt = root_b;
  end

  // Advance when the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end

endmodule

/* sv/tfn_div_step.sv */
// ----------------------------------------------------------------------------
// tfn_div_step: one registered stage of three parallel restoring dividers
// Produces one quotient bit per lane per stage.
// ----------------------------------------------------------------------------
module tfn_div_step (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tfn_pkg::LW:0]       den_i,
  input  logic [2:0][tfn_pkg::LW:0]  rem_i,
  input  logic [2:0][tfn_pkg::QW-1:0] quo_i,
  input  logic [2:0]                 nbit_i,
  output logic [2:0][tfn_pkg::LW:0]  rem_o,
  output logic [2:0][tfn_pkg::QW-1:0] quo_o
);

  logic [2:0][tfn_pkg::LW+1:0]  trial;
  logic [2:0][tfn_pkg::LW:0]    rem_nxt;
  logic [2:0][tfn_pkg::QW-1:0]  quo_nxt;

  // Shift in next numerator bit and try subtracting
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_i[i], nbit_i[i]};
      if (trial[i] >= {1'b0, den_i}) begin
        rem_nxt[i] = (tfn_pkg::LW+1)'(trial[i] - {1'b0, den_i});
        quo_nxt[i] = {quo_i[i][tfn_pkg::QW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][tfn_pkg::LW:0];
        quo_nxt[i] = {quo_i[i][tfn_pkg::QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      quo_o <= quo_nxt;
    end
  end

endmodule

/* sv/triangle_face_normal.sv */
// Pipeline order from input transfer to result: front end, sqrt, numerator,
// one divide stage per numerator bit, output.
// Throughput: one triangle per cycle while no result is stalled; every stage is a
// register slice that advances together under one global enable.
// Stall: when the output holds an unaccepted result, the whole pipe freezes.
// Reset: synchronous active-low rst_n clears all valid bits; data needs none.
// ----------------------------------------------------------------------------
// triangle_face_normal: unit normal of a triangle in signed Q1.14
// Edges, cross product, normalize, sqrt and three dividers, fully pipelined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module triangle_face_normal (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [23:0]      in_a_x,
  input  logic signed [23:0]      in_a_y,
  input  logic signed [23:0]      in_a_z,
  input  logic signed [23:0]      in_b_x,
  input  logic signed [23:0]      in_b_y,
  input  logic signed [23:0]      in_b_z,
  input  logic signed [23:0]      in_c_x,
  input  logic signed [23:0]      in_c_y,
  input  logic signed [23:0]      in_c_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      out_normal_x,
  output logic signed [15:0]      out_normal_y,
  output logic signed [15:0]      out_normal_z,
  output logic                    out_degenerate
);

  localparam int SqSt  = 16;
  localparam int NumW  = tfn_pkg::PW + 15;                             // (p<<14 + L/2) width
  localparam int DivSt = NumW;                                         // one stage per numerator bit
  localparam int Lat   = 9 + SqSt + DivSt;

  logic en;
  logic [Lat-1:0] vld_r;

  // Pipe moves unless a result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  // Stage 1: edges
  tfn_pkg::edge_t e1_r [3];
  tfn_pkg::edge_t e2_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= tfn_pkg::EdgeW'(in_b_x) - tfn_pkg::EdgeW'(in_a_x);
      e1_r[1] <= tfn_pkg::EdgeW'(in_b_y) - tfn_pkg::EdgeW'(in_a_y);
      e1_r[2] <= tfn_pkg::EdgeW'(in_b_z) - tfn_pkg::EdgeW'(in_a_z);
      e2_r[0] <= tfn_pkg::EdgeW'(in_c_x) - tfn_pkg::EdgeW'(in_a_x);
      e2_r[1] <= tfn_pkg::EdgeW'(in_c_y) - tfn_pkg::EdgeW'(in_a_y);
      e2_r[2] <= tfn_pkg::EdgeW'(in_c_z) - tfn_pkg::EdgeW'(in_a_z);
    end
  end

  // Stage 2: six 25x25 products
  logic signed [49:0] pa_r [3];
  logic signed [49:0] pb_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= 50'(e1_r[1]) * 50'(e2_r[2]);
      pb_r[0] <= 50'(e1_r[2]) * 50'(e2_r[1]);
      pa_r[1] <= 50'(e1_r[2]) * 50'(e2_r[0]);
      pb_r[1] <= 50'(e1_r[0]) * 50'(e2_r[2]);
      pa_r[2] <= 50'(e1_r[0]) * 50'(e2_r[1]);
      pb_r[2] <= 50'(e1_r[1]) * 50'(e2_r[0]);
    end
  end

  // Stage 3: cross components as sign and magnitude
  tfn_pkg::mag_t mag_r [3];
  logic [2:0] sgn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [tfn_pkg::CrossW-1:0] c;
        c = tfn_pkg::CrossW'(pa_r[i]) - tfn_pkg::CrossW'(pb_r[i]);
        sgn_r[i] <= c[tfn_pkg::CrossW-1];
        mag_r[i] <= c[tfn_pkg::CrossW-1] ? tfn_pkg::MagW'(-c) : tfn_pkg::MagW'(c);
      end
    end
  end

  // Stage 4: leading-one position of the largest magnitude (via the OR of all three)
  tfn_pkg::mag_t mag4_r [3];
  logic [2:0] sgn4_r;
  logic [5:0] lead_r;
  logic deg4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [tfn_pkg::MagW-1:0] m;
      logic [5:0] ld;
      m  = mag_r[0] | mag_r[1] | mag_r[2];
      ld = '0;
      for (int b = 0; b < tfn_pkg::MagW; b++) begin
        if (m[b]) ld = 6'(b);
      end
      lead_r <= ld;
      deg4_r <= (m == '0);
      mag4_r <= mag_r;
      sgn4_r <= sgn_r;
    end
  end

  // Stage 5: shift so the max lands in [2^29, 2^30)
  tfn_pkg::pmag_t p_r [3];
  logic [2:0] sgn5_r;
  logic deg5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (lead_r <= 6'd29) begin
          p_r[i] <= tfn_pkg::PW'(mag4_r[i] << (6'd29 - lead_r));
        end else begin
          p_r[i] <= tfn_pkg::PW'(mag4_r[i] >> (lead_r - 6'd29));
        end
      end
      sgn5_r <= sgn4_r;
      deg5_r <= deg4_r;
    end
  end

  // Stage 6: squares
  tfn_pkg::sq_t sq_r [3];
  tfn_pkg::pmag_t p6_r [3];
  logic [2:0] sgn6_r;
  logic deg6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= tfn_pkg::SW'(p_r[i]) * tfn_pkg::SW'(p_r[i]);
      end
      p6_r <= p_r; sgn6_r <= sgn5_r; deg6_r <= deg5_r;
    end
  end

  // Stage 7: sum of squares
  logic [tfn_pkg::SW:0] s_r;
  tfn_pkg::pmag_t p7_r [3];
  logic [2:0] sgn7_r;
  logic deg7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= (tfn_pkg::SW+1)'(sq_r[0]) + (tfn_pkg::SW+1)'(sq_r[1])
           + (tfn_pkg::SW+1)'(sq_r[2]);
      p7_r <= p6_r; sgn7_r <= sgn6_r; deg7_r <= deg6_r;
    end
  end

  // Square root chain, two bits per stage
  logic [tfn_pkg::SW:0] srem [SqSt+1];
  logic [tfn_pkg::LW:0] sroot [SqSt+1];
  assign srem[0]  = s_r;
  assign sroot[0] = '0;
  for (genvar g = 0; g < SqSt; g++) begin : g_sqrt
    tfn_sqrt_step #(.Stage(g)) u_step (
      .clk(clk), .en(en),
      .rem_i(srem[g]), .root_i(sroot[g]),
      .rem_o(srem[g+1]), .root_o(sroot[g+1])
    );
  end

  // Side data delay through the sqrt chain
  tfn_pkg::pmag_t pd_r [SqSt][3];
  logic [2:0] sgnd_r [SqSt];
  logic degd_r [SqSt];
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= p7_r; sgnd_r[0] <= sgn7_r; degd_r[0] <= deg7_r;
      for (int k = 1; k < SqSt; k++) begin
        pd_r[k] <= pd_r[k-1]; sgnd_r[k] <= sgnd_r[k-1]; degd_r[k] <= degd_r[k-1];
      end
    end
  end

  // Stage: numerators p*2^14 + L/2, divisor L (or 1 when degenerate)
  logic [tfn_pkg::LW:0] den_r;
  logic [NumW-1:0] num_r [3];
  logic [2:0] sgnn_r;
  logic degn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= (degd_r[SqSt-1]) ? (tfn_pkg::LW+1)'(1) : sroot[SqSt];
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= ({pd_r[SqSt-1][i], 14'd0}) + NumW'(sroot[SqSt] >> 1);
      end
      sgnn_r <= sgnd_r[SqSt-1];
      degn_r <= degd_r[SqSt-1];
    end
  end

  // Divider chain: one stage per numerator bit, fed from the numerator stage
  logic [2:0][tfn_pkg::LW:0]   drem [DivSt+1];
  logic [2:0][tfn_pkg::QW-1:0] dquo [DivSt+1];
  logic [NumW-1:0] dnum_r [DivSt][3];
  logic [tfn_pkg::LW:0] dden_r [DivSt];
  logic [2:0] dsgn_r [DivSt];
  logic ddeg_r [DivSt];
  logic [2:0] nbit [DivSt];
  assign drem[0] = '0;
  assign dquo[0] = '0;

  always_comb begin
    for (int k = 0; k < DivSt; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) nbit[k][i] = num_r[i][NumW-1];
        else        nbit[k][i] = dnum_r[k-1][i][NumW-1-k];
      end
    end
  end

  for (genvar g = 0; g < DivSt; g++) begin : g_div
    tfn_div_step u_step (
      .clk(clk), .en(en),
      .den_i((g == 0) ? den_r : dden_r[(g == 0) ? 0 : g-1]),
      .rem_i(drem[g]), .quo_i(dquo[g]), .nbit_i(nbit[g]),
      .rem_o(drem[g+1]), .quo_o(dquo[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnum_r[0] <= num_r; dden_r[0] <= den_r; dsgn_r[0] <= sgnn_r; ddeg_r[0] <= degn_r;
      for (int k = 1; k < DivSt; k++) begin
        dnum_r[k] <= dnum_r[k-1]; dden_r[k] <= dden_r[k-1];
        dsgn_r[k] <= dsgn_r[k-1]; ddeg_r[k] <= ddeg_r[k-1];
      end
    end
  end

  // Output register: clamp, sign, degenerate zeroing
  logic [2:0][tfn_pkg::NormW-1:0] nrm_r;
  logic deg_o_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [tfn_pkg::QW-1:0] q;
        q = (dquo[DivSt][i] > tfn_pkg::NormOne) ? tfn_pkg::NormOne : dquo[DivSt][i];
        if (ddeg_r[DivSt-1])          nrm_r[i] <= '0;
        else if (dsgn_r[DivSt-1][i])  nrm_r[i] <= -tfn_pkg::NormW'(q);
        else                          nrm_r[i] <= tfn_pkg::NormW'(q);
      end
      deg_o_r <= ddeg_r[DivSt-1];
    end
  end

  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = deg_o_r;

  `ASSERT_IMPL(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_normal_x))
  `ASSERT_IMPL(a_deg_zero, clk, rst_n, out_valid && out_degenerate,
    out_normal_x == 16'sd0 && out_normal_y == 16'sd0 && out_normal_z == 16'sd0)

endmodule
